### design/positional_array_list_assert.svh
// ----------------------------------------------------------------------------
// positional_array_list_assert.svh
// Assertion macros for the positional array list. Clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_LIST_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_ASSERT_SVH

`ifndef ASSERT_OFF

// property checked at every clock edge out of reset
`define PAL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked at every clock edge out of reset
`define PAL_ASSERT_IMP(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`else

`define PAL_ASSERT(label, prop, msg)
`define PAL_ASSERT_IMP(label, pre, post, msg)

`endif

`endif

### design/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg
// Types and constants shared by the positional array list modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pal_pkg;

	localparam int PAL_DEPTH         = 32;
	localparam int PAL_ELEMENT_WIDTH = 32;

	typedef enum logic [1:0] {
		OP_GET    = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef struct packed {
		op_t                operation;
		logic [5:0]         position;
		logic signed [31:0] value_in;
	} in_req_t;

	typedef struct packed {
		logic               status;
		logic signed [31:0] value_out;
		logic [5:0]         length_now;
	} out_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SHIFT_UP,
		ST_SHIFT_DN,
		ST_WRITE_NEW,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

### design/pal_ram.sv
// ----------------------------------------------------------------------------
// pal_ram
// Element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pal_ram #(
	parameter int DEPTH         = pal_pkg::PAL_DEPTH,
	parameter int ELEMENT_WIDTH = pal_pkg::PAL_ELEMENT_WIDTH
) (
	input  wire logic                         clk,
	input  wire logic                         we,
	input  wire logic [$clog2(DEPTH)-1:0]     waddr,
	input  wire logic [ELEMENT_WIDTH-1:0]     wdata,
	input  wire logic                         re,
	input  wire logic [$clog2(DEPTH)-1:0]     raddr,
	output logic      [ELEMENT_WIDTH-1:0]     rdata
);

	logic [ELEMENT_WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### design/pal_seq.sv
// ----------------------------------------------------------------------------
// pal_seq
// Request sequencer: range checks, length count and the element shift
// loop that moves one word per cycle through the element store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pal_seq #(
	parameter int DEPTH         = pal_pkg::PAL_DEPTH,
	parameter int ELEMENT_WIDTH = pal_pkg::PAL_ELEMENT_WIDTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire pal_pkg::in_req_t  in_data,
	output logic                   done_valid,
	input  wire logic              done_take,
	output pal_pkg::out_rsp_t      done_data
);

	localparam int IW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH + 1);
	localparam int CW = (LW > 6 ? LW : 6) + 1;

	pal_pkg::state_t  state_q, state_d;
	pal_pkg::in_req_t req_q;
	logic [LW-1:0]    len_q;
	logic [IW-1:0]    cur_q;
	logic [IW-1:0]    pidx_q;
	logic             status_q;
	logic [31:0]      value_q;

	logic                     we, re;
	logic [IW-1:0]            waddr, raddr;
	logic [ELEMENT_WIDTH-1:0] wdata, rdata;

	logic [CW-1:0] pos_c, len_c;
	logic          get_ok, ins_ok, ins_tail, acc;
	logic [IW-1:0] pidx_in, lidx;
	logic          at_pos, at_last;
	logic signed [63:0] rd_ext;

	pal_ram #(
		.DEPTH         (DEPTH),
		.ELEMENT_WIDTH (ELEMENT_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign pos_c    = CW'(in_data.position);
	assign len_c    = CW'(len_q);
	assign get_ok   = (pos_c != '0) && (pos_c <= len_c);
	assign ins_ok   = (len_c < CW'(DEPTH)) && (pos_c != '0) && (pos_c <= len_c + CW'(1));
	assign ins_tail = (pos_c == len_c + CW'(1));
	assign pidx_in  = IW'(pos_c - CW'(1));
	assign lidx     = IW'(len_c - CW'(1));
	assign acc      = in_valid && in_ready;
	assign at_pos   = (cur_q == pidx_q);
	assign at_last  = (CW'(cur_q) + CW'(1) == len_c);
	assign rd_ext   = 64'(signed'(rdata));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pal_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (in_data.operation)
						pal_pkg::OP_GET:    state_d = get_ok ? pal_pkg::ST_READ : pal_pkg::ST_DONE;
						pal_pkg::OP_INSERT: begin
							if (!ins_ok) begin
								state_d = pal_pkg::ST_DONE;
							end else if (ins_tail) begin
								state_d = pal_pkg::ST_WRITE_NEW;
							end else begin
								state_d = pal_pkg::ST_SHIFT_UP;
							end
						end
						pal_pkg::OP_DELETE: state_d = get_ok ? pal_pkg::ST_SHIFT_DN : pal_pkg::ST_DONE;
						default:            state_d = pal_pkg::ST_DONE;
					endcase
				end
			end
			pal_pkg::ST_READ:      state_d = pal_pkg::ST_DONE;
			pal_pkg::ST_SHIFT_UP:  state_d = at_pos ? pal_pkg::ST_WRITE_NEW : pal_pkg::ST_SHIFT_UP;
			pal_pkg::ST_SHIFT_DN:  state_d = at_last ? pal_pkg::ST_DONE : pal_pkg::ST_SHIFT_DN;
			pal_pkg::ST_WRITE_NEW: state_d = pal_pkg::ST_DONE;
			pal_pkg::ST_DONE:      state_d = done_take ? pal_pkg::ST_IDLE : pal_pkg::ST_DONE;
			default:               state_d = pal_pkg::ST_IDLE;
		endcase
	end

	// outputs and memory port controls
	always_comb begin
		in_ready   = 1'b0;
		done_valid = 1'b0;
		we         = 1'b0;
		re         = 1'b0;
		waddr      = cur_q;
		raddr      = cur_q;
		wdata      = rdata;
		case (state_q)
			pal_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				raddr    = (in_data.operation == pal_pkg::OP_INSERT) ? lidx : pidx_in;
				case (in_data.operation)
					pal_pkg::OP_GET,
					pal_pkg::OP_DELETE: re = in_valid && get_ok;
					pal_pkg::OP_INSERT: re = in_valid && ins_ok && !ins_tail;
					default:            re = 1'b0;
				endcase
			end
			pal_pkg::ST_SHIFT_UP: begin
				// move the word just read one place up, fetch the one below
				we    = 1'b1;
				waddr = cur_q + IW'(1);
				re    = !at_pos;
				raddr = cur_q - IW'(1);
			end
			pal_pkg::ST_SHIFT_DN: begin
				// first word read is the removed one; later ones move down
				we    = !at_pos;
				waddr = cur_q - IW'(1);
				re    = !at_last;
				raddr = cur_q + IW'(1);
			end
			pal_pkg::ST_WRITE_NEW: begin
				we    = 1'b1;
				waddr = pidx_q;
				wdata = ELEMENT_WIDTH'(req_q.value_in);
			end
			pal_pkg::ST_DONE: done_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pal_pkg::ST_IDLE;
			len_q   <= '0;
		end else begin
			state_q <= state_d;
			if (acc && in_data.operation == pal_pkg::OP_CLEAR) begin
				len_q <= '0;
			end else if (state_q == pal_pkg::ST_WRITE_NEW) begin
				len_q <= len_q + LW'(1);
			end else if (state_q == pal_pkg::ST_SHIFT_DN && at_last) begin
				len_q <= len_q - LW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pal_pkg::ST_IDLE: begin
				if (acc) begin
					req_q   <= in_data;
					pidx_q  <= pidx_in;
					cur_q   <= (in_data.operation == pal_pkg::OP_INSERT) ? lidx : pidx_in;
					value_q <= '0;
					case (in_data.operation)
						pal_pkg::OP_GET,
						pal_pkg::OP_DELETE: status_q <= !get_ok;
						pal_pkg::OP_INSERT: status_q <= !ins_ok;
						default:            status_q <= 1'b0;
					endcase
				end
			end
			pal_pkg::ST_READ: value_q <= rd_ext[31:0];
			pal_pkg::ST_SHIFT_UP: begin
				if (!at_pos) begin
					cur_q <= cur_q - IW'(1);
				end
			end
			pal_pkg::ST_SHIFT_DN: begin
				if (at_pos) begin
					value_q <= rd_ext[31:0];
				end
				if (!at_last) begin
					cur_q <= cur_q + IW'(1);
				end
			end
			default: ;
		endcase
	end

	assign done_data.status     = status_q;
	assign done_data.value_out  = value_q;
	assign done_data.length_now = 6'(len_q);

endmodule

`default_nettype wire

### design/positional_array_list.sv
// ----------------------------------------------------------------------------
// positional_array_list
// Bounded ordered list of signed words addressed by 1-based position.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready with in_data (operation, position,
//   value_in); each request gives exactly one result on out_valid/out_ready
//   with out_data (status, value_out, length_now).
//   One request is in work at a time. Clear and rejected requests go
//   straight to the result; get reads one element; insert at position p
//   moves the elements from p to the end one place up before writing the
//   new value, and delete at position p moves the elements after p one
//   place down.
//   Insert and delete move one element per cycle through the element store
//   (one read and one write port, registered read data); that shift loop
//   sets their duration, which grows with the number of elements moved.
//   A result held in the output register does not block the next
//   request. If the receiver stalls with the output register full, the
//   next finished result waits in the sequencer.
//   Reset empties the list (length zero); stored words are not cleared and
//   there is no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "positional_array_list_assert.svh"

module positional_array_list #(
	parameter int DEPTH         = pal_pkg::PAL_DEPTH,
	parameter int ELEMENT_WIDTH = pal_pkg::PAL_ELEMENT_WIDTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire pal_pkg::in_req_t  in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output pal_pkg::out_rsp_t      out_data
);

	logic              done_valid, done_take;
	pal_pkg::out_rsp_t done_data;
	logic              out_valid_q;
	pal_pkg::out_rsp_t out_data_q;
	logic              err_out;

	pal_seq #(
		.DEPTH         (DEPTH),
		.ELEMENT_WIDTH (ELEMENT_WIDTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.done_valid (done_valid),
		.done_take  (done_take),
		.done_data  (done_data)
	);

	assign done_take = done_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_take) begin
			out_data_q <= done_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign err_out   = out_valid && out_data.status;

	// one request in work at a time
	`PAL_ASSERT_IMP(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")
	// a handed-over result is not offered twice
	`PAL_ASSERT_IMP(a_done_once, done_take, !done_valid, "result handed over twice")
	// failed requests carry a zero value
	`PAL_ASSERT(a_err_zero, !err_out || (out_data.value_out == '0), "error result with value")

endmodule

`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the positional array list. A behavioral list model
// predicts status, value and length for every accepted request. Both channels
// are driven with random idle and stall cycles. Directed corner requests run
// first, then about 1900 random requests in fill, drain and mixed phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import pal_pkg::*;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	localparam int N_RANDOM    = 1900;
	localparam int PHASE_LEN   = 100;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_WAIT  = 40;

	typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} mode_t;

	class list_scoreboard;
		logic signed [31:0] elements[PAL_DEPTH];
		int                 length;
		out_rsp_t           expected_q[$];
		int                 errors;
		int                 op_count[4];
		int                 rejects;
		int                 full_rejects;
		int                 max_len;

		function new();
			length = 0;
			errors = 0;
			rejects = 0;
			full_rejects = 0;
			max_len = 0;
			foreach (op_count[i]) op_count[i] = 0;
		endfunction

		// list behavior for one request; updates the local copy of the list
		function out_rsp_t apply_list_op(in_req_t r);
			out_rsp_t e;
			int       p;
			int       k;
			p = r.position;
			e.status = STATUS_ERR;
			e.value_out = '0;
			op_count[int'(r.operation)]++;
			case (r.operation)
				OP_GET: begin
					if (p >= 1 && p <= length) begin
						e.value_out = elements[p-1];
						e.status = STATUS_OK;
					end
				end
				OP_INSERT: begin
					if (length < PAL_DEPTH && p >= 1 && p <= length + 1) begin
						for (k = length; k >= p; k--)
							elements[k] = elements[k-1];
						elements[p-1] = r.value_in;
						length++;
						e.status = STATUS_OK;
					end else if (length == PAL_DEPTH) begin
						full_rejects++;
					end
				end
				OP_DELETE: begin
					if (p >= 1 && p <= length) begin
						e.value_out = elements[p-1];
						for (k = p; k < length; k++)
							elements[k-1] = elements[k];
						length--;
						e.status = STATUS_OK;
					end
				end
				default: begin
					length = 0;
					e.status = STATUS_OK;
				end
			endcase
			if (e.status == STATUS_ERR)
				rejects++;
			if (length > max_len)
				max_len = length;
			e.length_now = length[5:0];
			return e;
		endfunction

		function void note_request(in_req_t r);
			expected_q.push_back(apply_list_op(r));
		endfunction

		function void check_result(out_rsp_t got);
			out_rsp_t e;
			if (expected_q.size() == 0) begin
				$error("result with no request outstanding: %p", got);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (got.status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, got.status);
				errors++;
			end
			if (got.value_out !== e.value_out) begin
				$error("value_out: expected %0d, got %0d", e.value_out, got.value_out);
				errors++;
			end
			if (got.length_now !== e.length_now) begin
				$error("length_now: expected %0d, got %0d", e.length_now, got.length_now);
				errors++;
			end
		endfunction
	endclass

	logic     clk = 1'b0;
	logic     arst_n;
	logic     in_valid = 1'b0;
	logic     in_ready;
	in_req_t  in_data = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	out_rsp_t out_data;

	bit             quiet = 1'b0;
	int             stall_cycles = 0;
	list_scoreboard sb = new();

	positional_array_list u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= quiet || ($urandom_range(99) >= 7);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_data);
	end

	// ends the run if neither channel moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic in_req_t make_req(op_t op, int pos, logic [31:0] val);
		in_req_t r;
		r.operation = op;
		r.position = pos[5:0];
		r.value_in = val;
		return r;
	endfunction

	function automatic in_req_t random_req(mode_t mode);
		in_req_t r;
		int      w;
		int      lim;
		int      sel;
		w = $urandom_range(99);
		case (mode)
			MODE_FILL:  r.operation = (w < 72) ? OP_INSERT : (w < 86) ? OP_GET : OP_DELETE;
			MODE_DRAIN: r.operation = (w < 65) ? OP_DELETE : (w < 80) ? OP_GET : OP_INSERT;
			default:    r.operation = (w < 38) ? OP_INSERT : (w < 68) ? OP_DELETE :
			                          (w < 97) ? OP_GET : OP_CLEAR;
		endcase
		lim = (r.operation == OP_INSERT) ? sb.length + 1 : sb.length;
		sel = $urandom_range(99);
		if (sel < 80)
			r.position = (lim > 0) ? 6'($urandom_range(lim, 1)) : 6'd1;
		else if (sel < 88)
			r.position = $urandom_range(1) ? 6'd0 : 6'(lim + 1);
		else
			r.position = 6'($urandom_range(63));
		case ($urandom_range(15))
			0:       r.value_in = 32'h7fff_ffff;
			1:       r.value_in = 32'h8000_0000;
			2:       r.value_in = '0;
			3:       r.value_in = '1;
			default: r.value_in = $urandom;
		endcase
		return r;
	endfunction

	task automatic send_req(input in_req_t r);
		if (!quiet && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		do @(posedge clk); while (!in_ready);
		sb.note_request(r);
	endtask

	initial begin
		mode_t mode;
		int    n;

		// scheduled so the falling edge reaches the block's reset
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list and out-of-range positions
		send_req(make_req(OP_GET, 1, 32'd0));
		send_req(make_req(OP_DELETE, 1, 32'd0));
		send_req(make_req(OP_GET, 0, 32'd0));
		send_req(make_req(OP_INSERT, 0, 32'h1234_5678));
		send_req(make_req(OP_INSERT, 2, 32'h1234_5678));
		// front, back and middle inserts with extreme values
		send_req(make_req(OP_INSERT, 1, 32'h7fff_ffff));
		send_req(make_req(OP_INSERT, 2, 32'h8000_0000));
		send_req(make_req(OP_INSERT, 1, 32'hffff_ffff));
		send_req(make_req(OP_INSERT, 2, 32'h0000_0000));
		for (n = 1; n <= 4; n++)
			send_req(make_req(OP_GET, n, 32'd0));
		send_req(make_req(OP_GET, 5, 32'd0));
		send_req(make_req(OP_GET, 63, 32'hffff_ffff));
		send_req(make_req(OP_INSERT, 63, 32'h0f0f_0f0f));
		send_req(make_req(OP_DELETE, 0, 32'd0));
		send_req(make_req(OP_DELETE, 5, 32'd0));
		send_req(make_req(OP_DELETE, 2, 32'd0));
		send_req(make_req(OP_DELETE, 3, 32'd0));
		send_req(make_req(OP_DELETE, 1, 32'd0));
		send_req(make_req(OP_CLEAR, 63, 32'hffff_ffff));
		send_req(make_req(OP_CLEAR, 0, 32'd0));
		send_req(make_req(OP_GET, 1, 32'd0));
		send_req(make_req(OP_INSERT, 1, 32'h5555_aaaa));

		// phases cycle fill / drain / mixed; two phases run without idling
		for (n = 0; n < N_RANDOM; n++) begin
			case ((n / PHASE_LEN) % 3)
				0:       mode = MODE_FILL;
				1:       mode = MODE_DRAIN;
				default: mode = MODE_MIXED;
			endcase
			quiet = (n / PHASE_LEN == 8) || (n / PHASE_LEN == 9);
			send_req(random_req(mode));
		end
		quiet = 1'b0;
		in_valid <= 1'b0;

		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Ran %0d get, %0d insert, %0d delete, %0d clear requests; %0d rejected",
			sb.op_count[OP_GET], sb.op_count[OP_INSERT], sb.op_count[OP_DELETE],
			sb.op_count[OP_CLEAR], sb.rejects);
		$display("Longest list %0d of %0d, %0d inserts refused on a full list",
			sb.max_len, PAL_DEPTH, sb.full_rejects);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### files.f
+incdir+design
design/pal_pkg.sv
design/pal_ram.sv
design/pal_seq.sv
design/positional_array_list.sv
tb/sv/tb.sv
